/* rtl/core/mbad_pkg.sv */
// types and address constants shared by the bus address decoder
package mbad_pkg;

  typedef enum logic [2:0] {
    T_MEM   = 3'd0,
    T_LOCAL = 3'd1,
    T_CONS  = 3'd2,
    T_DISK  = 3'd3,
    T_MMU   = 3'd4,
    T_NONE  = 3'd5
  } target_t;

  typedef enum logic [1:0] {
    CMD_RD_WORD = 2'd0,
    CMD_RD_BYTE = 2'd1,
    CMD_WR_WORD = 2'd2,
    CMD_WR_BYTE = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_ACCESS
  } state_t;

  localparam logic [15:0] SWITCH_RESET = 16'o173030;

  // local register addresses
  localparam logic [17:0] A_PS  = 18'o777776;
  localparam logic [17:0] A_LKS = 18'o777546;
  localparam logic [17:0] A_SR0 = 18'o777572;
  localparam logic [17:0] A_SR2 = 18'o777576;
  localparam logic [17:0] A_SWR = 18'o777570;

  // device windows
  localparam logic [17:0] CONS_MASK    = 18'o777770;
  localparam logic [17:0] CONS_BASE    = 18'o777560;
  localparam logic [17:0] DISK_RD_MASK = 18'o777760;
  localparam logic [17:0] DISK_WR_MASK = 18'o777700;
  localparam logic [17:0] DISK_BASE    = 18'o777400;
  localparam logic [17:0] MMU_MASK     = 18'o777600;
  localparam logic [17:0] MMU_BASE_LO  = 18'o772200;
  localparam logic [17:0] MMU_BASE_HI  = 18'o777600;

  // mode field code legal only as all kernel or all user
  function automatic logic mode_bad(input logic [1:0] m);
    return (m != 2'b00) && (m != 2'b11);
  endfunction

endpackage

/* rtl/core/mbad_ram.sv */
// generic single-port-write, registered-read ram
module mbad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/minicomputer_bus_address_decoder_top.sv */
// bus address decoder: word ram, local registers and device window decode
//
//   channel  direction  signals
//   in       input      in_valid / in_ready, cmd, address, wdata, mmu_status_two
//   out      output     out_valid / out_ready, rdata, target, byte_mask, device_wdata,
//                       bus_error, mode_error, current_user, previous_user
//   cfg      input      cfg_we, cfg_wdata (switch register value)
//
// each word passes through idle, where accept issues the ram read, and access, where it is decoded,
// merged and written back through the ram write port; no new word is taken until access ends
// the result sits in an output register; the next word is accepted while it waits
// a stalled output holds the decode cycle until the result register is free
// reset clears status, clock and mmu registers and control, presets the switch register; ram contents need no clearing
module minicomputer_bus_address_decoder_top #(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [17:0] address,
  input  logic [15:0] wdata,
  input  logic [15:0] mmu_status_two,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] rdata,
  output logic [2:0]  target,
  output logic [1:0]  byte_mask,
  output logic [15:0] device_wdata,
  output logic        bus_error,
  output logic        mode_error,
  output logic        current_user,
  output logic        previous_user,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import mbad_pkg::*;

  localparam int MEM_WORDS = (MEM_BYTES + 1) >> 1;
  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [17:0] MEM_LIMIT = 18'(MEM_BYTES);

  state_t state, state_next;

  logic [1:0]  cmd_q;
  logic [17:0] addr_q;
  logic [15:0] wdata_q;
  logic [15:0] sr2_q;

  logic [15:0] status_word, clock_status, mmu_status_zero, switch_value;
  logic [15:0] status_word_next, clock_status_next, mmu_status_zero_next;

  logic        in_fire, finish;
  logic [AW-1:0] ram_raddr;
  logic [15:0] ram_rdata;
  logic        ram_we;
  logic [15:0] ram_wdata;

  logic        is_byte, is_write, high;
  logic [1:0]  lanes;
  logic [17:0] w;
  logic [7:0]  wbyte;
  logic        mem_hit, local_hit, local_wr_hit;
  logic [15:0] local_val, merge_src, merged;
  target_t     dev_rd, dev_wr, mmu_t;
  logic [15:0] r_rdata, r_dwd;
  target_t     r_target;
  logic [1:0]  r_mask;
  logic        r_berr, r_merr;

  assign in_fire = in_valid && in_ready;

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        finish = !out_valid || out_ready;
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q   <= cmd;
      addr_q  <= address;
      wdata_q <= wdata;
      sr2_q   <= mmu_status_two;
    end
  end

  // read issued on accept, held address re-read while stalled
  assign ram_raddr = in_fire ? address[AW:1] : addr_q[AW:1];

  mbad_ram #(
    .WIDTH(16),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_q[AW:1]),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // decode of the held word
  assign is_byte  = cmd_q[0];
  assign is_write = cmd_q[1];
  assign high     = addr_q[0];
  assign lanes    = is_byte ? (high ? 2'd2 : 2'd1) : 2'd3;
  assign w        = {addr_q[17:1], 1'b0};
  assign wbyte    = wdata_q[7:0];
  assign mem_hit  = addr_q < MEM_LIMIT;

  always_comb begin
    local_hit = 1'b1;
    local_val = 16'd0;
    unique case (w)
      A_LKS:   local_val = clock_status;
      A_SWR:   local_val = switch_value;
      A_SR0:   local_val = mmu_status_zero;
      A_SR2:   local_val = sr2_q;
      A_PS:    local_val = status_word;
      default: local_hit = 1'b0;
    endcase
  end

  assign local_wr_hit = (w == A_PS) || (w == A_LKS) || (w == A_SR0);

  assign mmu_t  = ((w & MMU_MASK) == MMU_BASE_LO || (w & MMU_MASK) == MMU_BASE_HI) ?
                  T_MMU : T_NONE;
  assign dev_rd = ((w & CONS_MASK) == CONS_BASE) ? T_CONS :
                  ((w & DISK_RD_MASK) == DISK_BASE) ? T_DISK : mmu_t;
  assign dev_wr = ((w & CONS_MASK) == CONS_BASE) ? T_CONS :
                  ((w & DISK_WR_MASK) == DISK_BASE) ? T_DISK : mmu_t;

  // byte merge into the aligned word, memory or local register
  assign merge_src = mem_hit ? ram_rdata : local_val;
  always_comb begin
    if (!is_byte) begin
      merged = wdata_q;
    end else if (high) begin
      merged = {wbyte, merge_src[7:0]};
    end else begin
      merged = {merge_src[15:8], wbyte};
    end
  end

  always_comb begin
    r_rdata              = 16'd0;
    r_dwd                = 16'd0;
    r_target             = T_NONE;
    r_mask               = 2'd0;
    r_berr               = 1'b0;
    r_merr               = 1'b0;
    ram_we               = 1'b0;
    ram_wdata            = merged;
    status_word_next     = status_word;
    clock_status_next    = clock_status;
    mmu_status_zero_next = mmu_status_zero;
    if (!is_byte && high) begin
      r_berr = 1'b1;
    end else if (mem_hit) begin
      r_target = T_MEM;
      r_mask   = lanes;
      if (!is_write) begin
        r_rdata = is_byte ? {8'd0, (high ? ram_rdata[15:8] : ram_rdata[7:0])} : ram_rdata;
      end else begin
        ram_we = finish;
      end
    end else if (!is_write) begin
      if (local_hit) begin
        r_target = T_LOCAL;
        r_mask   = lanes;
        r_rdata  = is_byte ? {8'd0, (high ? local_val[15:8] : local_val[7:0])} : local_val;
      end else begin
        r_target = dev_rd;
        if (dev_rd == T_NONE) begin
          r_berr = 1'b1;
        end else begin
          r_mask = lanes;
        end
      end
    end else if (local_wr_hit) begin
      r_target = T_LOCAL;
      r_mask   = lanes;
      if (w == A_PS) begin
        if (mode_bad(merged[15:14]) || mode_bad(merged[13:12])) begin
          r_merr = 1'b1;
        end else begin
          status_word_next = merged;
        end
      end else if (w == A_LKS) begin
        clock_status_next = merged;
      end else begin
        mmu_status_zero_next = merged;
      end
    end else begin
      r_target = dev_wr;
      if (dev_wr == T_NONE) begin
        r_berr = 1'b1;
      end else begin
        r_mask = lanes;
        if (!is_byte) begin
          r_dwd = wdata_q;
        end else if (high) begin
          r_dwd = {wbyte, 8'd0};
        end else begin
          r_dwd = {8'd0, wbyte};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status_word     <= 16'd0;
      clock_status    <= 16'd0;
      mmu_status_zero <= 16'd0;
      switch_value    <= SWITCH_RESET;
    end else begin
      if (finish) begin
        status_word     <= status_word_next;
        clock_status    <= clock_status_next;
        mmu_status_zero <= mmu_status_zero_next;
      end
      if (cfg_we) begin
        switch_value <= cfg_wdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rdata         <= r_rdata;
      target        <= r_target;
      byte_mask     <= r_mask;
      device_wdata  <= r_dwd;
      bus_error     <= r_berr;
      mode_error    <= r_merr;
      current_user  <= status_word_next[15];
      previous_user <= status_word_next[12];
    end
  end

  a_berr_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_error |-> target == T_NONE && byte_mask == 2'd0 && rdata == 16'd0)
    else $error("bus error result carries a target or lanes");

  a_merr_local: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_error |-> target == T_LOCAL && !bus_error)
    else $error("mode error on a non-local access");

  a_merr_keeps_ps: assert property (@(posedge clk) disable iff (rst)
    finish && r_merr |=> $stable(status_word))
    else $error("status word changed on an invalid mode write");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("second word accepted before the first was decoded");

  a_write_no_rdata: assert property (@(posedge clk) disable iff (rst)
    out_valid && device_wdata != 16'd0 |-> rdata == 16'd0)
    else $error("forwarded write returned read data");

endmodule
